### src/rv32i_subset_execute_unit_core_assert.svh
// Assertion macros for the execute unit core
`ifndef RV32I_SUBSET_EXECUTE_UNIT_CORE_ASSERT_SVH
`define RV32I_SUBSET_EXECUTE_UNIT_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define EXU_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication checked in the cycle after the antecedent
`define EXU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### src/exu_pkg.sv
// Package: operation codes, classes, status codes and shared types
`default_nettype none
package exu_pkg;
   typedef enum logic [4:0] {
      OP_ADD = 5'd0, OP_ADDI = 5'd1, OP_AND = 5'd2, OP_ANDI = 5'd3, OP_PCREL = 5'd4,
      OP_BEQ = 5'd5, OP_BNE = 5'd6, OP_BGE = 5'd7, OP_BGEU = 5'd8, OP_BLT = 5'd9,
      OP_BLTU = 5'd10, OP_JAL = 5'd11, OP_JALR = 5'd12, OP_LB = 5'd13, OP_OR = 5'd14,
      OP_LBU = 5'd15, OP_LW = 5'd16, OP_LUI = 5'd17, OP_SLT = 5'd18, OP_SLTU = 5'd19,
      OP_ORI = 5'd20, OP_SB = 5'd21, OP_SLLI = 5'd22, OP_SRLI = 5'd23, OP_SRAI = 5'd24,
      OP_SUB = 5'd25, OP_SW = 5'd26, OP_XOR = 5'd27, OP_ENVCALL = 5'd28
   } op_type;

   localparam logic [1:0] ST_NORMAL = 2'd0;
   localparam logic [1:0] ST_HALT   = 2'd1;
   localparam logic [1:0] ST_ERROR  = 2'd2;

   localparam logic [2:0] CL_ALU    = 3'd0;
   localparam logic [2:0] CL_BRANCH = 3'd1;
   localparam logic [2:0] CL_JUMP   = 3'd2;
   localparam logic [2:0] CL_MEM    = 3'd3;
   localparam logic [2:0] CL_OTHER  = 3'd4;

   localparam logic [1:0] REG_DATA_BASE  = 2'd0;
   localparam logic [1:0] REG_DATA_LIMIT = 2'd1;
   localparam logic [1:0] REG_START_PC   = 2'd2;

   localparam logic [31:0] RESET_DATA_BASE  = 32'h0000_2000;
   localparam logic [31:0] RESET_DATA_LIMIT = 32'h0000_3FFF;
   localparam logic [4:0]  REG_A0 = 5'd10;
   localparam logic [4:0]  REG_A7 = 5'd17;
   localparam logic [31:0] ECALL_EXIT  = 32'd10;
   localparam logic [31:0] ECALL_PRINT = 32'd1;

   // result item
   typedef struct packed {
      logic [2:0]  instr_class;
      logic [31:0] print_value;
      logic        print_valid;
      logic [31:0] wb_value;
      logic [4:0]  wb_reg;
      logic        wb_valid;
      logic [31:0] next_pc;
      logic [1:0]  status;
   } rsp_type;

   // memory write request from execute logic
   typedef struct packed {
      logic        en;
      logic [3:0]  be;
      logic [31:0] addr;
      logic [31:0] data;
   } memwr_type;
endpackage
`default_nettype wire

### src/exu_ram.sv
// Generic single-port-write RAM with registered read
`default_nettype none
module exu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

### src/exu_alu.sv
// Combinational execute: ALU, branch, jump, address checks, ECALL
`default_nettype none
module exu_alu #(
   parameter int MEM_BYTES = 16384
) (
   input  wire logic [4:0]   op,
   input  wire logic [4:0]   rd,
   input  wire logic [31:0]  a,
   input  wire logic [31:0]  b,
   input  wire logic [31:0]  imm,
   input  wire logic [31:0]  pc,
   input  wire logic [31:0]  a7,
   input  wire logic [31:0]  a0,
   input  wire logic [31:0]  data_base,
   input  wire logic [31:0]  data_limit,
   output exu_pkg::rsp_type  res,
   output logic              is_load,
   output exu_pkg::memwr_type memwr
);
   import exu_pkg::*;
   logic [31:0] addr, last, pc4, sum_ai;
   logic        wide, ok, taken, wr, slt, sltu;
   logic [4:0]  sh;
   logic [31:0] wv;
   localparam logic [32:0] MemBytes = 33'(MEM_BYTES);

   always_comb begin
      pc4    = pc + 32'd4;
      sum_ai = a + imm;
      addr   = sum_ai;
      wide   = (op == OP_LW) || (op == OP_SW);
      last   = addr + (wide ? 32'd3 : 32'd0);
      ok     = (last >= addr) && (addr >= data_base) && (last <= data_limit)
               && ({1'b0, last} < MemBytes) && !(wide && (addr[1:0] != 2'b00));
      sh     = imm[4:0];
      slt    = $signed(a) < $signed(b);
      sltu   = a < b;
      taken  = 1'b0;
      wr     = 1'b0;
      wv     = '0;
      is_load = 1'b0;
      memwr  = '0;
      memwr.addr = addr;
      memwr.data = b;
      res = '0;
      res.status = ST_NORMAL;
      res.next_pc = pc4;
      res.instr_class = CL_OTHER;
      unique case (op)
         OP_ADD:   begin res.instr_class = CL_ALU; wr = 1'b1; wv = a + b; end
         OP_ADDI:  begin res.instr_class = CL_ALU; wr = 1'b1; wv = sum_ai; end
         OP_AND:   begin res.instr_class = CL_ALU; wr = 1'b1; wv = a & b; end
         OP_ANDI:  begin res.instr_class = CL_ALU; wr = 1'b1; wv = a & imm; end
         OP_PCREL: begin res.instr_class = CL_ALU; wr = 1'b1; wv = pc + imm; end
         OP_OR:    begin res.instr_class = CL_ALU; wr = 1'b1; wv = a | b; end
         OP_ORI:   begin res.instr_class = CL_ALU; wr = 1'b1; wv = a | imm; end
         OP_LUI:   begin res.instr_class = CL_ALU; wr = 1'b1; wv = imm; end
         OP_SLT:   begin res.instr_class = CL_ALU; wr = 1'b1; wv = {31'd0, slt}; end
         OP_SLTU:  begin res.instr_class = CL_ALU; wr = 1'b1; wv = {31'd0, sltu}; end
         OP_SLLI:  begin res.instr_class = CL_ALU; wr = 1'b1; wv = a << sh; end
         OP_SRLI:  begin res.instr_class = CL_ALU; wr = 1'b1; wv = a >> sh; end
         OP_SRAI:  begin res.instr_class = CL_ALU; wr = 1'b1; wv = 32'($signed(a) >>> sh); end
         OP_SUB:   begin res.instr_class = CL_ALU; wr = 1'b1; wv = a - b; end
         OP_XOR:   begin wr = 1'b1; wv = a ^ b; end
         OP_BEQ:   begin res.instr_class = CL_BRANCH; taken = (a == b); end
         OP_BNE:   begin res.instr_class = CL_BRANCH; taken = (a != b); end
         OP_BGE:   begin res.instr_class = CL_BRANCH; taken = !slt; end
         OP_BGEU:  begin res.instr_class = CL_BRANCH; taken = !sltu; end
         OP_BLT:   begin res.instr_class = CL_BRANCH; taken = slt; end
         OP_BLTU:  begin res.instr_class = CL_BRANCH; taken = sltu; end
         OP_JAL:   begin
            res.instr_class = CL_JUMP; wr = 1'b1; wv = pc4; res.next_pc = pc + imm;
         end
         OP_JALR:  begin
            res.instr_class = CL_JUMP; wr = 1'b1; wv = pc4;
            res.next_pc = {sum_ai[31:1], 1'b0};
         end
         OP_LB, OP_LBU, OP_LW: begin
            res.instr_class = CL_MEM;
            if (ok) begin
               wr = 1'b1; is_load = 1'b1;
            end else begin
               res.status = ST_ERROR;
            end
         end
         OP_SB, OP_SW: begin
            res.instr_class = CL_MEM;
            if (ok) begin
               memwr.en = 1'b1;
               memwr.be = wide ? 4'b1111 : (4'b0001 << addr[1:0]);
               memwr.data = wide ? b : {4{b[7:0]}};
            end else begin
               res.status = ST_ERROR;
            end
         end
         OP_ENVCALL: begin
            if (a7 == ECALL_EXIT) begin
               res.status = ST_HALT;
            end else if (a7 == ECALL_PRINT) begin
               res.print_valid = 1'b1; res.print_value = a0;
            end else begin
               res.status = ST_ERROR;
            end
         end
         default: res.status = ST_ERROR;
      endcase
      if (taken) begin
         res.next_pc = pc + imm;
      end
      if (wr && rd != 5'd0) begin
         res.wb_valid = 1'b1; res.wb_reg = rd; res.wb_value = wv;
      end
   end
endmodule
`default_nettype wire

### src/rv32i_subset_execute_unit_core.sv
// Top level: RV32I-subset execute unit with register file and data memory
//
//   channel | dir  | handshake              | payload
//   req     | in   | req_tvalid/req_tready  | req_tdata: type,rd,rs1,rs2,imm
//   rsp     | out  | rsp_tvalid/rsp_tready  | rsp_tdata: result fields
//   csr     | in   | APB psel/penable       | data_base, data_limit, start_pc
//
// Two stages: E executes with registers read combinationally from a flop
// file, bypassing the M-stage write, and issues data memory reads/writes;
// M takes the registered RAM read for loads, writes back and fills the
// output register. One item per cycle when rsp_tready stays high. A load
// result is forwarded from M to E in the same cycle. Data memory is four
// byte-lane RAMs of MEM_BYTES/4 words; after reset a clearing pass over
// all words zeroes them, during which req_tready is low. Stalls on rsp
// hold both stages; a held load keeps re-reading its own word.
`default_nettype none
`include "rv32i_subset_execute_unit_core_assert.svh"
module rv32i_subset_execute_unit_core #(
   parameter int MEM_BYTES = 16384
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // type[4:0], dest_reg[9:5], src_reg_a[14:10], src_reg_b[19:15], immediate[51:20]
   input  wire logic [55:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[1:0], next_pc[33:2], wb_valid[34], wb_reg[39:35], wb_value[71:40],
   // print_valid[72], print_value[104:73], instr_class[107:105]
   output logic [111:0]      rsp_tdata,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import exu_pkg::*;
   localparam int WORDS = MEM_BYTES / 4;
   localparam int AW = $clog2(WORDS);

   logic [31:0] data_base_ff, data_limit_ff, start_pc_ff, pc_ff;
   logic [31:0] regs_ff [32];
   logic        clr_ff;
   logic [AW-1:0] clr_addr_ff;
   // M stage
   logic        m_valid_ff, m_load_ff;
   rsp_type     m_res_ff;
   logic [4:0]  m_op_ff;
   logic [1:0]  m_lane_ff;
   logic [AW-1:0] m_raddr_ff;
   // output register
   logic        o_valid_ff;
   rsp_type     o_res_ff;

   logic        advance, e_fire, csr_wr;
   logic [4:0]  e_op, e_rd, e_rs1, e_rs2;
   logic [31:0] e_imm, e_a, e_b, m_wv, a7v, a0v;
   rsp_type     e_res, m_final;
   logic        e_load;
   memwr_type   e_memwr;
   logic [31:0] rdata;
   logic [7:0]  ld_byte;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_DATA_BASE:  csr_prdata = data_base_ff;
         REG_DATA_LIMIT: csr_prdata = data_limit_ff;
         REG_START_PC:   csr_prdata = start_pc_ff;
         default:        csr_prdata = '0;
      endcase
   end

   // output register frees when taken; M advances into it
   assign advance = !o_valid_ff || rsp_tready;
   assign req_tready = advance && !clr_ff;
   assign e_fire = req_tvalid && req_tready;
   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata = {4'd0, o_res_ff};

   assign e_op  = req_tdata[4:0];
   assign e_rd  = req_tdata[9:5];
   assign e_rs1 = req_tdata[14:10];
   assign e_rs2 = req_tdata[19:15];
   assign e_imm = req_tdata[51:20];

   // load data finishes in M
   always_comb begin
      ld_byte = rdata[8*m_lane_ff +: 8];
      if (m_op_ff == OP_LW) begin
         m_wv = rdata;
      end else if (m_op_ff == OP_LB) begin
         m_wv = {{24{ld_byte[7]}}, ld_byte};
      end else begin
         m_wv = {24'd0, ld_byte};
      end
      m_final = m_res_ff;
      if (m_load_ff && m_res_ff.wb_valid) begin
         m_final.wb_value = m_wv;
      end
   end

   // operand read with bypass of the M-stage write
   function automatic logic [31:0] rd_reg(input logic [4:0] idx, input logic [31:0] file_val,
                                          input logic mv, input rsp_type mr,
                                          input logic [31:0] mval);
      logic [31:0] v;
      v = file_val;
      if (mv && mr.wb_valid && mr.wb_reg == idx) begin
         v = mval;
      end
      return v;
   endfunction

   assign e_a = rd_reg(e_rs1, regs_ff[e_rs1], m_valid_ff, m_res_ff, m_final.wb_value);
   assign e_b = rd_reg(e_rs2, regs_ff[e_rs2], m_valid_ff, m_res_ff, m_final.wb_value);
   assign a7v = rd_reg(REG_A7, regs_ff[REG_A7], m_valid_ff, m_res_ff, m_final.wb_value);
   assign a0v = rd_reg(REG_A0, regs_ff[REG_A0], m_valid_ff, m_res_ff, m_final.wb_value);

   exu_alu #(.MEM_BYTES(MEM_BYTES)) u_alu (
      .op(e_op), .rd(e_rd), .a(e_a), .b(e_b), .imm(e_imm), .pc(pc_ff),
      .a7(a7v), .a0(a0v), .data_base(data_base_ff), .data_limit(data_limit_ff),
      .res(e_res), .is_load(e_load), .memwr(e_memwr)
   );

   // byte-lane data memory; while stalled the M word is read again
   logic [AW-1:0] ram_raddr, ram_waddr;
   assign ram_raddr = advance ? e_memwr.addr[AW+1:2] : m_raddr_ff;
   assign ram_waddr = clr_ff ? clr_addr_ff : e_memwr.addr[AW+1:2];
   for (genvar g = 0; g < 4; g++) begin : g_lane
      logic lane_we;
      assign lane_we = clr_ff || (e_fire && e_memwr.en && e_memwr.be[g]);
      exu_ram #(.WIDTH(8), .DEPTH(WORDS)) u_ram (
         .clock(clock), .we(lane_we), .waddr(ram_waddr),
         .wdata(clr_ff ? 8'd0 : e_memwr.data[8*g +: 8]),
         .raddr(ram_raddr), .rdata(rdata[8*g +: 8])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_base_ff  <= RESET_DATA_BASE;
         data_limit_ff <= RESET_DATA_LIMIT;
         start_pc_ff   <= '0;
         pc_ff         <= '0;
         clr_ff        <= 1'b1;
         clr_addr_ff   <= '0;
         m_valid_ff    <= 1'b0;
         o_valid_ff    <= 1'b0;
         for (int i = 0; i < 32; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         if (clr_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(WORDS - 1)) begin
               clr_ff <= 1'b0;
            end
         end
         if (csr_wr) begin
            case (csr_paddr[3:2])
               REG_DATA_BASE:  data_base_ff <= csr_pwdata;
               REG_DATA_LIMIT: data_limit_ff <= csr_pwdata;
               REG_START_PC: begin
                  start_pc_ff <= csr_pwdata;
                  pc_ff <= csr_pwdata;
               end
               default: ;
            endcase
         end
         if (advance) begin
            // retire M: write register file and fill output register
            if (m_valid_ff && m_final.wb_valid) begin
               regs_ff[m_final.wb_reg] <= m_final.wb_value;
            end
            o_valid_ff <= m_valid_ff;
            m_valid_ff <= e_fire;
            if (e_fire) begin
               pc_ff <= e_res.next_pc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         o_res_ff   <= m_final;
         m_res_ff   <= e_res;
         m_load_ff  <= e_load;
         m_op_ff    <= e_op;
         m_lane_ff  <= e_memwr.addr[1:0];
         m_raddr_ff <= e_memwr.addr[AW+1:2];
      end
   end

   `EXU_ASSERT_IMPL(a_no_accept_clear, clock, reset, clr_ff, !req_tready, "accept during clear")
   `EXU_ASSERT_NEXT(a_out_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp dropped")
   `EXU_ASSERT_IMPL(a_x0_never, clock, reset, rsp_tvalid && rsp_tdata[34], rsp_tdata[39:35] != 5'd0,
      "write to x0 reported")
endmodule
`default_nettype wire

### verif/exu_checker.sv
// Checker: watches the instruction and result streams, predicts and compares
`timescale 1ns / 100ps
`default_nettype none
module exu_checker #(
   parameter int MEM_BYTES = 16384
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [55:0]  req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [111:0] rsp_tdata,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   input  wire logic         csr_pready,
   output int                fail_count,
   output int                pending
);
   import exu_pkg::*;
   logic [31:0] win_base, win_limit, pc;
   logic [31:0] gpr [32];
   logic [7:0]  dmem [MEM_BYTES];
   rsp_type     expected_q[$];

   function automatic logic window_ok(input logic [31:0] addr, input logic [31:0] n);
      logic [31:0] last;
      last = addr + n - 32'd1;
      return !(last < addr || addr < win_base || last > win_limit
               || last >= MEM_BYTES);
   endfunction

   // executes one instruction on the shadow state and returns its result item
   function automatic rsp_type execute(input logic [55:0] d);
      rsp_type r;
      logic [4:0]  op, rd;
      logic [31:0] a, b, imm, npc, wv, addr;
      logic        wr, taken;
      op = d[4:0]; rd = d[9:5]; a = gpr[d[14:10]]; b = gpr[d[19:15]]; imm = d[51:20];
      npc = pc + 32'd4; wv = '0; wr = 1'b0; taken = 1'b0;
      r = '0; r.status = ST_NORMAL; r.instr_class = CL_OTHER;
      addr = a + imm;
      case (op)
         OP_ADD:   begin r.instr_class = CL_ALU; wr = 1'b1; wv = a + b; end
         OP_ADDI:  begin r.instr_class = CL_ALU; wr = 1'b1; wv = a + imm; end
         OP_AND:   begin r.instr_class = CL_ALU; wr = 1'b1; wv = a & b; end
         OP_ANDI:  begin r.instr_class = CL_ALU; wr = 1'b1; wv = a & imm; end
         OP_PCREL: begin r.instr_class = CL_ALU; wr = 1'b1; wv = pc + imm; end
         OP_OR:    begin r.instr_class = CL_ALU; wr = 1'b1; wv = a | b; end
         OP_ORI:   begin r.instr_class = CL_ALU; wr = 1'b1; wv = a | imm; end
         OP_LUI:   begin r.instr_class = CL_ALU; wr = 1'b1; wv = imm; end
         OP_SLT:   begin
            r.instr_class = CL_ALU; wr = 1'b1; wv = {31'd0, $signed(a) < $signed(b)};
         end
         OP_SLTU:  begin r.instr_class = CL_ALU; wr = 1'b1; wv = {31'd0, a < b}; end
         OP_SLLI:  begin r.instr_class = CL_ALU; wr = 1'b1; wv = a << imm[4:0]; end
         OP_SRLI:  begin r.instr_class = CL_ALU; wr = 1'b1; wv = a >> imm[4:0]; end
         OP_SRAI:  begin r.instr_class = CL_ALU; wr = 1'b1; wv = $signed(a) >>> imm[4:0]; end
         OP_SUB:   begin r.instr_class = CL_ALU; wr = 1'b1; wv = a - b; end
         OP_XOR:   begin wr = 1'b1; wv = a ^ b; end
         OP_BEQ:   begin r.instr_class = CL_BRANCH; taken = a == b; end
         OP_BNE:   begin r.instr_class = CL_BRANCH; taken = a != b; end
         OP_BGE:   begin r.instr_class = CL_BRANCH; taken = $signed(a) >= $signed(b); end
         OP_BGEU:  begin r.instr_class = CL_BRANCH; taken = a >= b; end
         OP_BLT:   begin r.instr_class = CL_BRANCH; taken = $signed(a) < $signed(b); end
         OP_BLTU:  begin r.instr_class = CL_BRANCH; taken = a < b; end
         OP_JAL:   begin
            r.instr_class = CL_JUMP; wr = 1'b1; wv = pc + 32'd4; npc = pc + imm;
         end
         OP_JALR:  begin
            r.instr_class = CL_JUMP; wr = 1'b1; wv = pc + 32'd4; npc = (a + imm) & ~32'd1;
         end
         OP_LB, OP_LBU: begin
            r.instr_class = CL_MEM;
            if (!window_ok(addr, 32'd1)) r.status = ST_ERROR;
            else begin
               wr = 1'b1; wv = {24'd0, dmem[addr]};
               if (op == OP_LB && wv[7]) wv[31:8] = '1;
            end
         end
         OP_LW: begin
            r.instr_class = CL_MEM;
            if (!window_ok(addr, 32'd4) || addr[1:0] != 2'd0) r.status = ST_ERROR;
            else begin
               wr = 1'b1; wv = {dmem[addr+3], dmem[addr+2], dmem[addr+1], dmem[addr]};
            end
         end
         OP_SB: begin
            r.instr_class = CL_MEM;
            if (!window_ok(addr, 32'd1)) r.status = ST_ERROR;
            else dmem[addr] = b[7:0];
         end
         OP_SW: begin
            r.instr_class = CL_MEM;
            if (!window_ok(addr, 32'd4) || addr[1:0] != 2'd0) r.status = ST_ERROR;
            else begin
               dmem[addr] = b[7:0]; dmem[addr+1] = b[15:8];
               dmem[addr+2] = b[23:16]; dmem[addr+3] = b[31:24];
            end
         end
         OP_ENVCALL: begin
            if (gpr[REG_A7] == ECALL_EXIT) r.status = ST_HALT;
            else if (gpr[REG_A7] == ECALL_PRINT) begin
               r.print_valid = 1'b1; r.print_value = gpr[REG_A0];
            end else r.status = ST_ERROR;
         end
         default: r.status = ST_ERROR;
      endcase
      if (taken) npc = pc + imm;
      if (wr && rd != 5'd0) begin
         gpr[rd] = wv; r.wb_valid = 1'b1; r.wb_reg = rd; r.wb_value = wv;
      end
      pc = npc;
      r.next_pc = npc;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type got, want;
      if (reset) begin
         win_base = RESET_DATA_BASE; win_limit = RESET_DATA_LIMIT; pc = '0;
         foreach (gpr[i]) gpr[i] = '0;
         foreach (dmem[i]) dmem[i] = '0;
         expected_q.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_DATA_BASE:  win_base = csr_pwdata;
               REG_DATA_LIMIT: win_limit = csr_pwdata;
               REG_START_PC:   pc = csr_pwdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) expected_q.push_back(execute(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[107:0];
            if (expected_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected result item %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display({"mismatch: st %0d/%0d pc %h/%h wb %b %0d %h/%b %0d %h",
                               " pr %b %h/%b %h cl %0d/%0d"},
                        want.status, got.status, want.next_pc, got.next_pc,
                        want.wb_valid, want.wb_reg, want.wb_value,
                        got.wb_valid, got.wb_reg, got.wb_value,
                        want.print_valid, want.print_value, got.print_valid,
                        got.print_value, want.instr_class, got.instr_class);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= expected_q.size();
      end
   end
endmodule
`default_nettype wire

### verif/tb.sv
// Testbench top: clock, reset, instruction stimulus, config writes and verdict
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import exu_pkg::*;

   localparam int MEM_BYTES = 16384;
   localparam int CYCLE_LIMIT = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [55:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;
   logic         csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [3:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;
   int           fail_count, pending, cycles = 0;
   int           rsp_wait = 0;      // idle cycles left before the next item is taken
   bit           hold_rsp = 1'b0;   // long receiver hold-off in progress

   always #5 clock = ~clock;

   rv32i_subset_execute_unit_core #(.MEM_BYTES(MEM_BYTES)) DUT (.*);

   exu_checker #(.MEM_BYTES(MEM_BYTES)) checker_i (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .rsp_tvalid, .rsp_tready,
      .rsp_tdata, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_pready, .fail_count, .pending);

   // receiver: idle count drawn per item, none taken while hold_rsp is set
   always @(posedge clock) begin
      if (reset || hold_rsp) begin
         rsp_tready <= 1'b0;
      end else if (rsp_tready && rsp_tvalid) begin
         rsp_wait = $urandom_range(0, 6);
         rsp_tready <= (rsp_wait == 0);
      end else if (!rsp_tready) begin
         if (rsp_wait == 0) rsp_tready <= 1'b1;
         else rsp_wait = rsp_wait - 1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= {idx, 2'b00}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   // offer one instruction, wait for acceptance; gaps drawn per item
   task automatic issue(input logic [4:0] op, input logic [4:0] rd, input logic [4:0] rs1,
                        input logic [4:0] rs2, input logic [31:0] imm, input bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 6));
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, imm, rs2, rs1, rd, op};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // window-relative address offsets so loads/stores mostly land in range
   function automatic logic [31:0] mem_imm(input logic [31:0] lo, input logic [31:0] hi);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return $urandom();
      if (r == 1) return hi - 32'($urandom_range(0, 4));
      if (r == 2) return lo + 32'($urandom_range(0, 4));
      return lo + 32'($urandom_range(0, 255)) * 4;
   endfunction

   task automatic random_run(input int n, input logic [31:0] lo, input logic [31:0] hi,
                             input bit no_gap = 0);
      logic [4:0] op, rd;
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 19);
         rd = 5'($urandom_range(0, 31));
         if (r < 4) issue((r == 0 ? OP_SW : r == 1 ? OP_LW : r == 2 ? OP_SB : OP_LBU),
                          rd, 5'd0, 5'($urandom_range(0, 31)), mem_imm(lo, hi), no_gap);
         else if (r == 4) issue(($urandom_range(0, 1) ? OP_LB : OP_SW), rd,
                                5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                                mem_imm(lo, hi) - 32'($urandom_range(0, 64)), no_gap);
         else if (r == 5) issue(OP_ADDI, ($urandom_range(0, 1) ? REG_A7 : REG_A0), 5'd0, 5'd0,
                                ($urandom_range(0, 2) == 0 ? ECALL_EXIT :
                                 $urandom_range(0, 2) == 0 ? $urandom() : ECALL_PRINT), no_gap);
         else if (r == 6) issue(OP_ENVCALL, rd, 5'd0, 5'd0, $urandom(), no_gap);
         else if (r == 7) issue(OP_LUI, rd, 5'd0, 5'd0,
                                ($urandom_range(0, 1) ? $urandom() : 32'h8000_0000), no_gap);
         else begin
            op = 5'($urandom_range(0, 31));
            issue(op, rd, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                  ($urandom_range(0, 3) == 0 ? 32'($signed($urandom_range(0, 64)) - 32) :
                   $urandom()), no_gap);
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: window extremes, every operation, x0 writes, ECALL cases
      issue(OP_LUI,  5'd1, 5'd0, 5'd0, 32'h8000_0000);
      issue(OP_ADDI, 5'd2, 5'd0, 5'd0, 32'hFFFF_FFFF);
      issue(OP_ADDI, 5'd0, 5'd2, 5'd0, 32'd5);                 // x0 stays zero
      issue(OP_SW,   5'd0, 5'd0, 5'd1, RESET_DATA_BASE);        // lowest byte of window
      issue(OP_SW,   5'd0, 5'd0, 5'd2, RESET_DATA_LIMIT - 3);   // last word
      issue(OP_SW,   5'd0, 5'd0, 5'd2, RESET_DATA_LIMIT - 1);   // misaligned
      issue(OP_LB,   5'd3, 5'd0, 5'd0, RESET_DATA_BASE + 3);
      issue(OP_LBU,  5'd4, 5'd0, 5'd0, RESET_DATA_LIMIT);
      issue(OP_LB,   5'd5, 5'd0, 5'd0, RESET_DATA_LIMIT + 1);   // past the window
      issue(OP_LW,   5'd6, 5'd2, 5'd0, 32'd0);                  // wrapping address
      issue(OP_SB,   5'd0, 5'd0, 5'd2, RESET_DATA_BASE - 1);    // below window
      issue(OP_SRAI, 5'd7, 5'd1, 5'd0, 32'hFFFF_FFFF);          // shift masked to 31
      issue(OP_BLT,  5'd0, 5'd1, 5'd2, 32'hFFFF_FFF0);
      issue(OP_BGEU, 5'd0, 5'd1, 5'd2, 32'd8);
      issue(OP_JALR, 5'd8, 5'd2, 5'd0, 32'd3);
      issue(OP_ADDI, REG_A7, 5'd0, 5'd0, ECALL_PRINT);
      issue(OP_ENVCALL, 5'd0, 5'd0, 5'd0, 32'd0);
      issue(OP_ADDI, REG_A7, 5'd0, 5'd0, ECALL_EXIT);
      issue(OP_ENVCALL, 5'd0, 5'd0, 5'd0, 32'd0);
      issue(OP_ADDI, REG_A7, 5'd0, 5'd0, 32'd7);
      issue(OP_ENVCALL, 5'd0, 5'd0, 5'd0, 32'd0);
      for (int op = 0; op < 32; op++) issue(5'(op), 5'(op), 5'd1, 5'd2, 32'h7FFF_FFFF);
      drain();

      // full-range window, nonzero start
      csr_write(REG_DATA_BASE, 32'd0);
      csr_write(REG_DATA_LIMIT, 32'hFFFF_FFFF);
      csr_write(REG_START_PC, 32'hFFFF_FFF8);
      random_run(400, 32'd0, 32'(MEM_BYTES));
      drain();

      // receiver holds off for a long stretch while items keep coming
      fork
         begin hold_rsp <= 1'b1; repeat (60) @(posedge clock); hold_rsp <= 1'b0; end
         random_run(40, 32'd0, 32'(MEM_BYTES), 1'b1);
      join
      drain();

      csr_write(REG_DATA_BASE, 32'd1024);
      csr_write(REG_DATA_LIMIT, 32'd2047);
      csr_write(REG_START_PC, 32'h0000_0100);
      random_run(400, 32'd1024, 32'd2047);
      drain();

      // window above the memory: every access fails
      csr_write(REG_DATA_BASE, 32'hFFFF_FF00);
      csr_write(REG_DATA_LIMIT, 32'hFFFF_FFFF);
      random_run(200, 32'hFFFF_FF00, 32'hFFFF_FFFF);
      drain();

      csr_write(REG_DATA_BASE, RESET_DATA_BASE);
      csr_write(REG_DATA_LIMIT, RESET_DATA_LIMIT);
      csr_write(REG_START_PC, 32'd0);
      random_run(560, RESET_DATA_BASE, RESET_DATA_LIMIT);
      drain();

      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire
